### src/m4mn_pkg.sv
`default_nettype none

package m4mn_pkg;

  localparam int DW    = 32;
  localparam int FB    = 16;
  localparam int ELEMS = 16;
  localparam int DIM   = 4;
  localparam int IDX_W = 4;
  localparam int SEL_W = 2;
  localparam int NUM_W = DW + FB;
  localparam int ACC_W = 2 * DW + 2;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ELEMS - 1);

  typedef struct packed {
    logic [IDX_W-1:0]     elem_index;
    logic signed [DW-1:0] a_value;
    logic signed [DW-1:0] b_value;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]     out_index;
    logic signed [DW-1:0] out_value;
    logic                 last;
    logic                 overflow;
    logic                 zero_divisor;
  } out_item_t;

  typedef struct packed {
    logic                 vld;
    logic [IDX_W-1:0]     idx;
    logic signed [DW-1:0] value;
    logic                 ovf;
  } prod_wr_t;

  typedef struct packed {
    logic                 done;
    logic                 ovf;
    logic signed [DW-1:0] quo;
  } div_res_t;

endpackage

`default_nettype wire

### src/m4mn_dot.sv
`default_nettype none

module m4mn_dot import m4mn_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 load_en,
  input  wire logic [IDX_W-1:0]     load_idx,
  input  wire logic signed [DW-1:0] load_a,
  input  wire logic signed [DW-1:0] load_b,
  input  wire logic                 run_start,
  output prod_wr_t                  prod_wr
);

  localparam int CNT_W = IDX_W + SEL_W;
  localparam int SH_W  = ACC_W - FB;

  logic signed [DW-1:0] left_mem  [ELEMS];
  logic signed [DW-1:0] right_mem [ELEMS];

  logic                 run_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [IDX_W-1:0]     k;
  logic [SEL_W-1:0]     i;
  logic [IDX_W-1:0]     la;
  logic [IDX_W-1:0]     ra;
  logic signed [DW-1:0] l_rd_r;
  logic signed [DW-1:0] r_rd_r;
  logic                 s1_vld_r;
  logic [IDX_W-1:0]     s1_k_r;
  logic [SEL_W-1:0]     s1_i_r;
  logic signed [2*DW-1:0] prod_r;
  logic                 s2_vld_r;
  logic [IDX_W-1:0]     s2_k_r;
  logic [SEL_W-1:0]     s2_i_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_nxt;
  logic                 fin_r;
  logic [IDX_W-1:0]     fin_k_r;
  logic signed [SH_W-1:0] sh;
  logic [SH_W-DW:0]     top_bits;
  logic                 sat;

  assign k  = cnt_r[CNT_W-1:SEL_W];
  assign i  = cnt_r[SEL_W-1:0];
  assign la = {i, k[SEL_W-1:0]};
  assign ra = {k[IDX_W-1:SEL_W], i};

  always_ff @(posedge clk) begin
    if (load_en) begin
      left_mem[load_idx]  <= load_a;
      right_mem[load_idx] <= load_b;
    end
    l_rd_r <= left_mem[la];
    r_rd_r <= right_mem[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r    <= 1'b0;
      cnt_r    <= '0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      fin_r    <= 1'b0;
    end else begin
      if (run_start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (&cnt_r) begin
          run_r <= 1'b0;
        end
      end
      s1_vld_r <= run_r;
      s2_vld_r <= s1_vld_r;
      fin_r    <= s2_vld_r && (&s2_i_r);
    end
  end

  assign acc_nxt = (s2_i_r == '0) ? ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);

  always_ff @(posedge clk) begin
    s1_k_r  <= k;
    s1_i_r  <= i;
    prod_r  <= l_rd_r * r_rd_r;
    s2_k_r  <= s1_k_r;
    s2_i_r  <= s1_i_r;
    fin_k_r <= s2_k_r;
    if (s2_vld_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign sh       = acc_r[ACC_W-1:FB];
  assign top_bits = sh[SH_W-1:DW-1];
  assign sat      = !((&top_bits) || !(|top_bits));

  always_comb begin
    prod_wr.vld = fin_r;
    prod_wr.idx = fin_k_r;
    prod_wr.ovf = sat;
    if (!sat) begin
      prod_wr.value = sh[DW-1:0];
    end else if (sh[SH_W-1]) begin
      prod_wr.value = {1'b1, {(DW-1){1'b0}}};
    end else begin
      prod_wr.value = {1'b0, {(DW-1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

### src/m4mn_div.sv
`default_nettype none

module m4mn_div import m4mn_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic signed [DW-1:0] x,
  input  wire logic signed [DW-1:0] d,
  output div_res_t                  res
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             run_r;
  logic             fin_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] num_r;
  logic [NUM_W-1:0] quo_r;
  logic [DW-1:0]    rem_r;
  logic [DW-1:0]    md_r;
  logic             neg_r;
  logic [DW-1:0]    mx;
  logic [DW:0]      rem_sh;
  logic [DW:0]      diff;
  logic [NUM_W-1:0] lim;
  logic             sat;
  logic [DW-1:0]    qs;
  div_res_t         res_r;

  assign mx     = x[DW-1] ? (~x + 1'b1) : x;
  assign rem_sh = {rem_r, num_r[NUM_W-1]};
  assign diff   = rem_sh - {1'b0, md_r};
  assign lim    = neg_r ? (NUM_W'(1) << (DW - 1)) : ((NUM_W'(1) << (DW - 1)) - 1'b1);
  assign sat    = quo_r > lim;
  assign qs     = sat ? lim[DW-1:0] : quo_r[DW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r      <= 1'b0;
      fin_r      <= 1'b0;
      cnt_r      <= '0;
      res_r.done <= 1'b0;
    end else begin
      fin_r      <= 1'b0;
      res_r.done <= fin_r;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          run_r <= 1'b0;
          fin_r <= 1'b1;
        end
      end
      if (fin_r) begin
        res_r.ovf <= sat;
        res_r.quo <= neg_r ? (~qs + 1'b1) : qs;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= {mx, {FB{1'b0}}};
      md_r  <= d[DW-1] ? (~d + 1'b1) : d;
      neg_r <= x[DW-1] ^ d[DW-1];
      rem_r <= '0;
      quo_r <= '0;
    end else if (run_r) begin
      num_r <= {num_r[NUM_W-2:0], 1'b0};
      if (!diff[DW]) begin
        rem_r <= diff[DW-1:0];
        quo_r <= {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[DW-1:0];
        quo_r <= {quo_r[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign res = res_r;

endmodule

`default_nettype wire

### src/matrix4_multiply_normalize.sv
// channel   ports                        timing
// input     start, busy, in_item         taken when start is high and busy is low
// result    out_valid, out_item          one cycle per item, no back-pressure
//
// indices 0..14 are stored and raise no busy
// index 15 starts a run: a mac pass through its pipeline, then per element
// read, load, 48 divide steps and finish; with a zero divisor only read and
// load, and the stored product is driven as the result
// busy stays high from the index 15 item until the last result is driven
// reset clears all control; the stores hold no reset value
`default_nettype none

module matrix4_multiply_normalize import m4mn_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MAC  = 5'b00010,
    ST_RD   = 5'b00100,
    ST_LD   = 5'b01000,
    ST_DIV  = 5'b10000
  } state_t;

  state_t               state_r, state_nxt;
  logic [IDX_W-1:0]     k_r, k_nxt;
  logic                 accept;
  logic                 run_start;
  prod_wr_t             prod_wr;
  div_res_t             div_res;
  logic                 div_start;
  logic [DW:0]          prod_mem [ELEMS];
  logic [DW:0]          prd_rd_r;
  logic signed [DW-1:0] d_r;
  logic                 zd_r;
  logic                 acc_ovf_r;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_item_r, out_item_nxt;

  assign accept    = start && !busy;
  assign run_start = accept && (in_item.elem_index == LAST_IDX);
  assign busy      = (state_r != ST_IDLE);

  m4mn_dot u_dot (
    .clk      (clk),
    .rst_n    (rst_n),
    .load_en  (accept),
    .load_idx (in_item.elem_index),
    .load_a   (in_item.a_value),
    .load_b   (in_item.b_value),
    .run_start(run_start),
    .prod_wr  (prod_wr)
  );

  m4mn_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .x    (prd_rd_r[DW-1:0]),
    .d    (d_r),
    .res  (div_res)
  );

  always_ff @(posedge clk) begin
    if (prod_wr.vld) begin
      prod_mem[prod_wr.idx] <= {prod_wr.ovf, prod_wr.value};
    end
    prd_rd_r <= prod_mem[k_r];
    if (prod_wr.vld && (prod_wr.idx == LAST_IDX)) begin
      d_r  <= prod_wr.value;
      zd_r <= (prod_wr.value == '0);
    end
    if (state_r == ST_LD) begin
      acc_ovf_r <= prd_rd_r[DW];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    div_start     = 1'b0;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    case (state_r)
      ST_IDLE: begin
        if (run_start) begin
          state_nxt = ST_MAC;
        end
      end
      ST_MAC: begin
        if (prod_wr.vld && (prod_wr.idx == LAST_IDX)) begin
          k_nxt     = '0;
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        state_nxt = ST_LD;
      end
      ST_LD: begin
        if (zd_r) begin
          out_valid_nxt             = 1'b1;
          out_item_nxt.out_index    = k_r;
          out_item_nxt.out_value    = prd_rd_r[DW-1:0];
          out_item_nxt.last         = (k_r == LAST_IDX);
          out_item_nxt.overflow     = prd_rd_r[DW];
          out_item_nxt.zero_divisor = 1'b1;
          k_nxt                     = k_r + 1'b1;
          state_nxt                 = (k_r == LAST_IDX) ? ST_IDLE : ST_RD;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          out_valid_nxt             = 1'b1;
          out_item_nxt.out_index    = k_r;
          out_item_nxt.out_value    = div_res.quo;
          out_item_nxt.last         = (k_r == LAST_IDX);
          out_item_nxt.overflow     = acc_ovf_r || div_res.ovf;
          out_item_nxt.zero_divisor = 1'b0;
          k_nxt                     = k_r + 1'b1;
          state_nxt                 = (k_r == LAST_IDX) ? ST_IDLE : ST_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last |-> out_item.out_index == LAST_IDX)
    else $error("last flag on wrong element");

  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    run_start |=> busy)
    else $error("run started without busy");

  a_spaced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("results in adjacent cycles");

endmodule

`default_nettype wire
